FILE: hdl/assert_macros.svh
// Assertion macros shared by the scheduler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold on every clock edge outside reset.
`define WWS_ASSERT_ALWAYS(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("wws assertion failed");

// Consequent must hold on every edge at which the antecedent holds.
`define WWS_ASSERT_IMP(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("wws assertion failed");

`endif

FILE: hdl/wws_pkg.sv
// Types, constants and helper functions of the weekly window scheduler.
`timescale 1ns / 1ps
package wws_pkg;

  localparam int unsigned SecsPerDay  = 86400;
  localparam int unsigned DaysPerWeek = 7;

  localparam int unsigned WDAY_W = 3;
  localparam int unsigned SEC_W  = 17;
  localparam int unsigned MASK_W = 7;
  localparam int unsigned STC_W  = 20;
  localparam int unsigned MARK_W = 19;  // signed: start moved back a day can go negative
  localparam int unsigned SUM_W  = 21;
  localparam int unsigned CFG_W  = 17;

  localparam logic [SEC_W-1:0]         SEC_MAX   = SEC_W'(SecsPerDay - 1);
  localparam logic signed [MARK_W-1:0] DAY_MARK  = MARK_W'(SecsPerDay);
  localparam logic [MASK_W-1:0]        MASK_ALL  = '1;
  localparam logic [WDAY_W-1:0]        WDAY_LAST = WDAY_W'(DaysPerWeek - 1);
  localparam logic [STC_W-1:0]         STC_MAX   = STC_W'(SecsPerDay * DaysPerWeek);

  typedef enum logic [1:0] {
    CFG_DAY_MASK = 2'd0,
    CFG_START    = 2'd1,
    CFG_STOP     = 2'd2,
    CFG_ENABLED  = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [MASK_W-1:0] day_mask;
    logic [SEC_W-1:0]  start_second;
    logic [SEC_W-1:0]  stop_second;
    logic              enabled;
  } cfg_t;

  // After decode: mask rotated so bit k is day today+k, window edges moved for wrap.
  typedef struct packed {
    logic                     enabled;
    logic [MASK_W-1:0]        rot;
    logic [SEC_W-1:0]         now;
    logic signed [MARK_W-1:0] start;
    logic signed [MARK_W-1:0] stop;
    logic                     equal;
  } s1_t;

  typedef struct packed {
    logic                     enabled;
    logic                     open;
    logic                     far;
    logic [WDAY_W-1:0]        days;
    logic signed [MARK_W-1:0] mark;
    logic [SEC_W-1:0]         now;
  } s2_t;

  typedef struct packed {
    logic             turned_on;
    logic             in_window;
    logic [STC_W-1:0] seconds_to_change;
  } res_t;

  function automatic logic [MASK_W-1:0] rot_mask(logic [MASK_W-1:0] mask,
                                                 logic [WDAY_W-1:0] day);
    logic [MASK_W-1:0] r;
    logic [WDAY_W:0]   idx;
    for (int k = 0; k < DaysPerWeek; k++) begin
      idx = {1'b0, day} + (WDAY_W+1)'(k);
      if (idx >= (WDAY_W+1)'(DaysPerWeek)) begin
        idx = idx - (WDAY_W+1)'(DaysPerWeek);
      end
      r[k] = mask[idx[WDAY_W-1:0]];
    end
    return r;
  endfunction

  function automatic logic [SEC_W-1:0] sat_sec(logic [SEC_W-1:0] v);
    return (v > SEC_MAX) ? SEC_MAX : v;
  endfunction

  function automatic logic [STC_W-1:0] day_base(logic [WDAY_W-1:0] days);
    return STC_W'(32'(days) * SecsPerDay);
  endfunction

endpackage

FILE: hdl/wws_ifs.sv
// Valid/ready channel interfaces for time samples and scheduler results.
`timescale 1ns / 1ps
interface wws_in_if;
  logic                        valid;
  logic                        ready;
  logic [wws_pkg::WDAY_W-1:0]  weekday;
  logic [wws_pkg::SEC_W-1:0]   second_of_day;

  modport source (output valid, output weekday, output second_of_day, input ready);
  modport sink   (input valid, input weekday, input second_of_day, output ready);
endinterface

interface wws_out_if;
  logic                        valid;
  logic                        ready;
  logic                        turned_on;
  logic                        in_window;
  logic [wws_pkg::STC_W-1:0]   seconds_to_change;

  modport source (output valid, output turned_on, output in_window,
                  output seconds_to_change, input ready);
  modport sink   (input valid, input turned_on, input in_window,
                  input seconds_to_change, output ready);
endinterface

FILE: hdl/wws_decode.sv
// Stage 1: saturate times, rotate the day mask, resolve a window that wraps midnight.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module wws_decode (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  output logic                       ready_o,
  input  logic [wws_pkg::WDAY_W-1:0] weekday_i,
  input  logic [wws_pkg::SEC_W-1:0]  second_i,
  input  wws_pkg::cfg_t              cfg_i,
  output logic                       valid_o,
  input  logic                       ready_i,
  output wws_pkg::s1_t               data_o
);
  import wws_pkg::*;

  logic              valid_q;
  s1_t               data_q, data_d;
  logic [WDAY_W-1:0] day;
  logic [MASK_W-1:0] mask;
  logic [SEC_W-1:0]  s_sat, e_sat;
  logic              wrap, late;

  always_comb begin
    day   = (weekday_i > WDAY_LAST) ? '0 : weekday_i;
    mask  = (cfg_i.day_mask == '0) ? MASK_ALL : cfg_i.day_mask;
    s_sat = sat_sec(cfg_i.start_second);
    e_sat = sat_sec(cfg_i.stop_second);
    data_d.now = sat_sec(second_i);
    wrap = s_sat > e_sat;
    late = data_d.now >= e_sat;
    data_d.enabled = cfg_i.enabled;
    data_d.rot     = rot_mask(mask, day);
    data_d.equal   = s_sat == e_sat;
    data_d.start   = $signed({2'b00, s_sat});
    data_d.stop    = $signed({2'b00, e_sat});
    // before stop: window began yesterday; otherwise it ends tomorrow
    if (wrap && !late) begin
      data_d.start = $signed({2'b00, s_sat}) - DAY_MARK;
    end
    if (wrap && late) begin
      data_d.stop = $signed({2'b00, e_sat}) + DAY_MARK;
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

  `WWS_ASSERT_IMP(a_window_ordered, clk_i, rst_ni, valid_q, data_q.start <= data_q.stop)
endmodule

FILE: hdl/wws_eval.sv
// Stage 2: decide whether the window is open and search the days for the next change.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module wws_eval (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         valid_i,
  output logic         ready_o,
  input  wws_pkg::s1_t data_i,
  output logic         valid_o,
  input  logic         ready_i,
  output wws_pkg::s2_t data_o
);
  import wws_pkg::*;

  logic                     valid_q;
  s2_t                      data_q, data_d;
  logic signed [MARK_W-1:0] now_s;
  logic                     cur, prev, want;

  always_comb begin
    now_s = $signed({2'b00, data_i.now});
    cur   = data_i.rot[0];
    prev  = data_i.rot[MASK_W-1];
    data_d.enabled = data_i.enabled;
    data_d.now     = data_i.now;
    data_d.open    = 1'b0;
    if (cur || prev) begin
      if (cur && data_i.equal) begin
        data_d.open = 1'b1;
      end else if (data_i.start <= now_s && now_s < data_i.stop) begin
        // a part begun yesterday needs yesterday in the mask
        data_d.open = (prev && data_i.start < 0) || (cur && data_i.start >= 0);
      end
    end

    if (data_i.equal) begin
      data_d.far  = 1'b1;
      want        = !data_d.open;
      data_d.mark = '0;
    end else if (data_d.open) begin
      data_d.far  = now_s > data_i.stop;
      want        = 1'b0;
      data_d.mark = data_i.stop;
    end else begin
      data_d.far  = now_s > data_i.start;
      want        = 1'b1;
      data_d.mark = data_i.start;
    end

    // nearest following day whose mask bit matches; sixth day when none does
    data_d.days = WDAY_W'(DaysPerWeek - 1);
    for (int k = DaysPerWeek - 1; k >= 1; k--) begin
      if (data_i.rot[k] == want) begin
        data_d.days = WDAY_W'(k);
      end
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

  `WWS_ASSERT_IMP(a_days_range, clk_i, rst_ni, valid_q, data_q.days != '0 && data_q.days <= WDAY_LAST)
endmodule

FILE: hdl/wws_time.sv
// Stage 3: seconds to the next change, held in the output register.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module wws_time (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  wws_pkg::s2_t  data_i,
  output logic          valid_o,
  input  logic          ready_i,
  output wws_pkg::res_t data_o
);
  import wws_pkg::*;

  logic                    valid_q;
  res_t                    data_q, data_d;
  logic [STC_W-1:0]        base;
  logic signed [SUM_W-1:0] sum;

  always_comb begin
    base = data_i.far ? day_base(data_i.days) : '0;
    sum  = $signed({1'b0, base})
         + $signed({{(SUM_W-MARK_W){data_i.mark[MARK_W-1]}}, data_i.mark})
         - $signed({{(SUM_W-SEC_W){1'b0}}, data_i.now});
    data_d.turned_on         = data_i.enabled;
    data_d.in_window         = data_i.open;
    data_d.seconds_to_change = sum[SUM_W-1] ? '0 : sum[STC_W-1:0];
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

  `WWS_ASSERT_IMP(a_secs_bound, clk_i, rst_ni, valid_q, data_q.seconds_to_change < STC_MAX)
endmodule

FILE: hdl/weekly_window_scheduler_unit.sv
// Weekly window scheduler: config registers and a three-stage evaluation pipeline.
// Each input transfer passes through the decode, eval and time registers before its result is offered.
// Throughput: one item per cycle; each stage advances when its successor has room.
// Reset: asynchronous, clears all stage valid bits; day_mask 127, start/stop 0, enabled 0.
// A stalled result holds in the output register while earlier stages keep filling.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module weekly_window_scheduler_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  wws_in_if.sink                    item_i,
  wws_out_if.source                 result_o,
  input  logic                      cfg_we_i,
  input  wws_pkg::cfg_idx_e         cfg_idx_i,
  input  logic [wws_pkg::CFG_W-1:0] cfg_data_i
);
  import wws_pkg::*;

  cfg_t cfg_q;
  logic v1, r2, v2, r3, v3;
  s1_t  d1;
  s2_t  d2;
  res_t d3;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.day_mask     <= MASK_ALL;
      cfg_q.start_second <= '0;
      cfg_q.stop_second  <= '0;
      cfg_q.enabled      <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DAY_MASK: cfg_q.day_mask     <= cfg_data_i[MASK_W-1:0];
        CFG_START:    cfg_q.start_second <= cfg_data_i[SEC_W-1:0];
        CFG_STOP:     cfg_q.stop_second  <= cfg_data_i[SEC_W-1:0];
        CFG_ENABLED:  cfg_q.enabled      <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  wws_decode u_decode (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (item_i.valid),
    .ready_o   (item_i.ready),
    .weekday_i (item_i.weekday),
    .second_i  (item_i.second_of_day),
    .cfg_i     (cfg_q),
    .valid_o   (v1),
    .ready_i   (r2),
    .data_o    (d1)
  );

  wws_eval u_eval (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v1),
    .ready_o (r2),
    .data_i  (d1),
    .valid_o (v2),
    .ready_i (r3),
    .data_o  (d2)
  );

  wws_time u_time (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v2),
    .ready_o (r3),
    .data_i  (d2),
    .valid_o (v3),
    .ready_i (result_o.ready),
    .data_o  (d3)
  );

  assign result_o.valid             = v3;
  assign result_o.turned_on         = d3.turned_on;
  assign result_o.in_window         = d3.in_window;
  assign result_o.seconds_to_change = d3.seconds_to_change;

  // a full pipeline with a stalled output must push back on the input
  `WWS_ASSERT_IMP(a_full_stall, clk_i, rst_ni, v1 && v2 && v3 && !result_o.ready, !item_i.ready)
endmodule

FILE: verif/weekly_window_scheduler_unit_test.sv
// Self-checking testbench for the weekly window scheduler: directed windows plus random schedules.
`timescale 1ns / 1ps
module weekly_window_scheduler_unit_test;
  import wws_pkg::*;

  localparam int DAY_SECS   = 86400;
  localparam int WEEK_DAYS  = 7;
  localparam int PIPE_DEPTH = 3;
  localparam int PHASES     = 29;
  localparam int PHASE_ITEMS = 50;

  logic clk_i;
  logic rst_ni;
  logic cfg_we;
  cfg_idx_e cfg_idx;
  logic [CFG_W-1:0] cfg_data;

  wws_in_if  item_if ();
  wws_out_if res_if ();

  weekly_window_scheduler_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .item_i     (item_if),
    .result_o   (res_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  // Shadow copy of the window registers.
  logic [MASK_W-1:0] win_mask;
  logic [SEC_W-1:0]  win_start;
  logic [SEC_W-1:0]  win_stop;
  logic              win_en;

  res_t pending_schedule[$];
  int   mismatches = 0;
  bit   quiet;
  int   stall_left;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("weekly_window_scheduler_unit_test: FAIL");
    $finish;
  end

  function automatic int clamp_sec(input logic [SEC_W-1:0] v);
    return (v > SEC_W'(DAY_SECS - 1)) ? DAY_SECS - 1 : int'(v);
  endfunction

  // Seconds to the midnight starting the next day whose mask bit equals want, or day six ahead if none does.
  function automatic int secs_to_edge(input logic [MASK_W-1:0] m, input int today,
                                      input int now, input bit want);
    int  cnt;
    bit  found;
    cnt   = -1;
    found = 1'b0;
    for (int k = 1; k < WEEK_DAYS; k++) begin
      if (!found) begin
        cnt++;
        if (m[(today + k) % WEEK_DAYS] == want) found = 1'b1;
      end
    end
    return DAY_SECS - now + cnt * DAY_SECS;
  endfunction

  function automatic res_t schedule_eval(input logic [WDAY_W-1:0] wd,
                                         input logic [SEC_W-1:0] sec);
    res_t              r;
    logic [MASK_W-1:0] m;
    int                d, now, s, e, secs;
    bit                cur, prv, win_open;
    m        = (win_mask == '0) ? MASK_ALL : win_mask;
    d        = int'(wd) % WEEK_DAYS;
    now      = clamp_sec(sec);
    s        = clamp_sec(win_start);
    e        = clamp_sec(win_stop);
    cur      = m[d];
    prv      = m[(d + WEEK_DAYS - 1) % WEEK_DAYS];
    win_open = 1'b0;
    // stop before start: window crosses midnight
    if (s > e) begin
      if (now < e) s -= DAY_SECS;
      else e += DAY_SECS;
    end
    if (cur || prv) begin
      if (cur && s == e) win_open = 1'b1;
      else if (s <= now && now < e) win_open = (prv && s < 0) || (cur && s >= 0);
    end
    if (s == e) begin
      secs = secs_to_edge(m, d, now, !win_open);
    end else if (win_open) begin
      if (now > e) secs = secs_to_edge(m, d, now, 1'b0) + e;
      else secs = e - now;
    end else begin
      if (now > s) secs = secs_to_edge(m, d, now, 1'b1) + s;
      else secs = s - now;
    end
    if (secs < 0) secs = 0;
    r.turned_on         = win_en;
    r.in_window         = win_open;
    r.seconds_to_change = STC_W'(secs);
    return r;
  endfunction

  // Mostly short pauses, a few long ones, none at all in quiet phases.
  function automatic int pick_pause();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  task automatic send_sample(input logic [WDAY_W-1:0] wd, input logic [SEC_W-1:0] sec);
    int gap;
    item_if.valid         <= 1'b1;
    item_if.weekday       <= wd;
    item_if.second_of_day <= sec;
    do @(posedge clk_i); while (!item_if.ready);
    pending_schedule.push_back(schedule_eval(wd, sec));
    gap = pick_pause();
    if (gap > 0) begin
      item_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Drain the pipeline so the registers can be rewritten safely.
  task automatic wait_idle();
    item_if.valid <= 1'b0;
    while (pending_schedule.size() != 0) @(posedge clk_i);
    repeat (PIPE_DEPTH + 1) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    case (idx)
      CFG_DAY_MASK: win_mask  = data[MASK_W-1:0];
      CFG_START:    win_start = data[SEC_W-1:0];
      CFG_STOP:     win_stop  = data[SEC_W-1:0];
      CFG_ENABLED:  win_en    = data[0];
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_window(input logic [MASK_W-1:0] m, input logic [SEC_W-1:0] s,
                            input logic [SEC_W-1:0] e, input logic en);
    wait_idle();
    write_reg(CFG_DAY_MASK, CFG_W'(m));
    write_reg(CFG_START, CFG_W'(s));
    write_reg(CFG_STOP, CFG_W'(e));
    write_reg(CFG_ENABLED, CFG_W'(en));
  endtask

  task automatic test_reset_state();
    send_sample(3'd0, 17'd0);
    send_sample(3'd6, 17'd86399);
    send_sample(3'd7, 17'd43200);
    send_sample(3'd3, 17'd131071);
  endtask

  task automatic test_plain_window();
    set_window(7'b0010101, 17'd3600, 17'd7200, 1'b1);
    send_sample(3'd0, 17'd3599);
    send_sample(3'd0, 17'd3600);
    send_sample(3'd0, 17'd7199);
    send_sample(3'd0, 17'd7200);
    send_sample(3'd1, 17'd5000);
    send_sample(3'd4, 17'd80000);
  endtask

  task automatic test_wrapped_window();
    set_window(7'b1000001, 17'd79200, 17'd21600, 1'b0);
    send_sample(3'd0, 17'd1000);
    send_sample(3'd1, 17'd1000);
    send_sample(3'd2, 17'd1000);
    send_sample(3'd0, 17'd80000);
    send_sample(3'd6, 17'd80000);
  endtask

  task automatic test_full_day_window();
    // zero mask reads as every day
    set_window(7'b0000000, 17'd50000, 17'd50000, 1'b1);
    send_sample(3'd2, 17'd0);
    send_sample(3'd5, 17'd86399);
    set_window(7'b1111110, 17'd50000, 17'd50000, 1'b0);
    send_sample(3'd0, 17'd100);
    send_sample(3'd6, 17'd100);
  endtask

  task automatic test_saturation();
    set_window(7'b1111111, 17'd131071, 17'd100000, 1'b1);
    send_sample(3'd3, 17'd86399);
    send_sample(3'd3, 17'd131071);
    set_window(7'b1111111, 17'd0, 17'd131071, 1'b0);
    send_sample(3'd3, 17'd86398);
    send_sample(3'd3, 17'd131071);
  endtask

  function automatic logic [MASK_W-1:0] pick_mask();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return MASK_ALL;
      2: return MASK_W'(1 << $urandom_range(0, 6));
      3: return MASK_ALL ^ MASK_W'(1 << $urandom_range(0, 6));
      default: return MASK_W'($urandom_range(0, 127));
    endcase
  endfunction

  function automatic logic [SEC_W-1:0] pick_mark();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return SEC_W'(DAY_SECS - 1);
      2: return SEC_W'($urandom_range(DAY_SECS, 131071));
      default: return SEC_W'($urandom_range(0, DAY_SECS - 1));
    endcase
  endfunction

  // Bias sample times toward window edges and midnight, with some past the last second of the day.
  function automatic logic [SEC_W-1:0] pick_second();
    int v;
    case ($urandom_range(0, 9))
      0, 1: v = clamp_sec(win_start) + int'($urandom_range(0, 2)) - 1;
      2, 3: v = clamp_sec(win_stop) + int'($urandom_range(0, 2)) - 1;
      4:    v = ($urandom_range(0, 1) != 0) ? 0 : DAY_SECS - 1;
      5:    v = $urandom_range(DAY_SECS, 131071);
      default: v = $urandom_range(0, DAY_SECS - 1);
    endcase
    if (v < 0) v = 0;
    if (v > 131071) v = 131071;
    return SEC_W'(v);
  endfunction

  task automatic test_random_schedules();
    logic [SEC_W-1:0] s;
    logic [SEC_W-1:0] e;
    for (int p = 0; p < PHASES; p++) begin
      s = pick_mark();
      e = ($urandom_range(0, 7) == 0) ? s : pick_mark();
      set_window(pick_mask(), s, e, 1'($urandom_range(0, 1)));
      quiet = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        send_sample(WDAY_W'($urandom_range(0, 7)), pick_second());
      end
      quiet = 1'b0;
    end
  endtask

  // Result side: random backpressure and comparison against the oldest prediction.
  initial begin
    res_t want;
    res_if.ready = 1'b0;
    stall_left   = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && res_if.valid && res_if.ready) begin
        if (pending_schedule.size() == 0) begin
          $error("result transfer with no prediction pending");
          mismatches++;
        end else begin
          want = pending_schedule.pop_front();
          if (res_if.turned_on !== want.turned_on) begin
            $error("turned_on: expected %0d, actual %0d", want.turned_on, res_if.turned_on);
            mismatches++;
          end
          if (res_if.in_window !== want.in_window) begin
            $error("in_window: expected %0d, actual %0d", want.in_window, res_if.in_window);
            mismatches++;
          end
          if (res_if.seconds_to_change !== want.seconds_to_change) begin
            $error("seconds_to_change: expected %0d, actual %0d",
                   want.seconds_to_change, res_if.seconds_to_change);
            mismatches++;
          end
        end
      end
      if (stall_left > 0) begin
        res_if.ready <= 1'b0;
        stall_left--;
      end else begin
        res_if.ready <= 1'b1;
        stall_left = pick_pause();
      end
    end
  end

  initial begin
    quiet                 = 1'b0;
    rst_ni                = 1'b0;
    cfg_we                = 1'b0;
    cfg_idx               = CFG_DAY_MASK;
    cfg_data              = '0;
    item_if.valid         = 1'b0;
    item_if.weekday       = '0;
    item_if.second_of_day = '0;
    win_mask              = MASK_ALL;
    win_start             = '0;
    win_stop              = '0;
    win_en                = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_plain_window();
    test_wrapped_window();
    test_full_day_window();
    test_saturation();
    test_random_schedules();
    wait_idle();

    if (mismatches == 0 && pending_schedule.size() == 0) begin
      $display("weekly_window_scheduler_unit_test: PASS");
    end else begin
      $display("weekly_window_scheduler_unit_test: FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/wws_pkg.sv
hdl/wws_ifs.sv
hdl/wws_decode.sv
hdl/wws_eval.sv
hdl/wws_time.sv
hdl/weekly_window_scheduler_unit.sv
verif/weekly_window_scheduler_unit_test.sv
